// ===== rtl/core/tdpf_pkg.sv =====
// Shared types and constants for the trial-division prime filter.
// No dependencies; imported by the divider, the sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tdpf_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
    logic q_ge_d;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdpf_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdpf_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tdpf_serial_div #(
  parameter int NW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NW-1:0]      dividend,
  input  logic [NW-1:0]      divisor,
  output tdpf_pkg::div_stat_t stat
);
  import tdpf_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] pr_r, pr_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [NW:0]   sh;
  logic [NW:0]   diff;
  logic          ge;

  assign sh   = {pr_r, num_r[NW-1]};
  assign ge   = sh >= {1'b0, divisor};
  assign diff = sh - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    pr_nxt   = pr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      num_nxt  = dividend;
      pr_nxt   = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      pr_nxt  = ge ? diff[NW-1:0] : sh[NW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    pr_r  <= pr_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (pr_r == '0);
  assign stat.q_ge_d   = (quo_r >= divisor);

endmodule

`default_nettype wire

// ===== rtl/core/tdpf_sequencer.sv =====
// Candidate sequencer: bound check, divisor stepping (2, 3, then 6k-1 / 6k+1), verdict.
// Depends on tdpf_pkg for the state enum and the divider status struct.
`timescale 1ns / 1ps
`default_nettype none

module tdpf_sequencer #(
  parameter int NW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NW-1:0]      cand,
  input  logic [NW-1:0]      bound,
  output logic               div_start,
  output logic [NW-1:0]      dividend,
  output logic [NW-1:0]      divisor,
  input  tdpf_pkg::div_stat_t stat,
  input  logic               out_free,
  output logic               emit,
  output logic [NW-1:0]      value
);
  import tdpf_pkg::*;

  seq_state_t    state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic          step4_r, step4_nxt;
  logic [NW-1:0] d_inc;

  always_comb begin
    if (d_r == NW'(2)) begin
      d_inc = NW'(1);
    end else if (d_r == NW'(3)) begin
      d_inc = NW'(2);
    end else if (step4_r) begin
      d_inc = NW'(4);
    end else begin
      d_inc = NW'(2);
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    step4_nxt = step4_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt     = cand;
          d_nxt     = NW'(2);
          step4_nxt = 1'b0;
          if (cand >= bound || cand < NW'(2)) begin
            state_nxt = ST_IDLE;
          end else if (cand < NW'(4)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.done) begin
          if (!stat.q_ge_d) begin
            state_nxt = ST_EMIT;
          end else if (stat.rem_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_START;
            d_nxt     = d_r + d_inc;
            if (d_r >= NW'(5)) begin
              step4_nxt = !step4_r;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_START: div_start = 1'b1;
      ST_WAIT:  ;
      ST_EMIT:  emit      = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step4_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step4_r <= step4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    d_r <= d_nxt;
  end

  assign dividend = n_r;
  assign divisor  = d_r;
  assign value    = n_r;

endmodule

`default_nettype wire

// ===== rtl/core/trial_division_prime_filter.sv =====
// Top level of the trial-division prime filter: bound register, output register.
// Depends on tdpf_pkg, tdpf_serial_div and tdpf_sequencer.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+------------------------------
//   in_     | in  | in_tvalid / in_tready   | in_tdata  = candidate
//   out_    | out | out_tvalid / out_tready | out_tdata = prime_value
//   cfg_    | in  | cfg_wr_en               | cfg_wr_data = upper_bound
//
// A dropped candidate (at or above the bound, or below 2) starts no division; 2 and 3 go
// straight to the output. Otherwise each divisor tried is one pass of the W-bit divider
// (W = min(VALUE_WIDTH, 32)), and about sqrt(n)/3 + 2 divisors are tried for a prime n.
// One candidate is in work at a time; in_tready is high only while the sequencer is idle.
// A pending result in the output register stalls the sequencer only when the next one is ready.
// Synchronous active-low reset; upper_bound resets to all ones.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_filter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] candidate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] prime_value
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data   // [31:0] upper_bound
);
  import tdpf_pkg::*;

  localparam int NW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

  logic [FIELD_W-1:0] bound_r;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_data_r;
  logic               out_free;
  logic               div_start;
  logic [NW-1:0]      dividend;
  logic [NW-1:0]      divisor;
  div_stat_t          div_stat;
  logic               emit;
  logic [NW-1:0]      emit_value;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= '1;
    end else if (cfg_wr_en) begin
      bound_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= FIELD_W'(emit_value);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tdpf_sequencer #(
    .NW(NW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cand     (in_tdata[NW-1:0]),
    .bound    (bound_r[NW-1:0]),
    .div_start(div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .out_free (out_free),
    .emit     (emit),
    .value    (emit_value)
  );

  tdpf_serial_div #(
    .NW(NW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dividend),
    .divisor (divisor),
    .stat    (div_stat)
  );

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("input ready while a division runs");

  a_emit_value: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (emit_value >= NW'(2)) && (emit_value[0] || emit_value == NW'(2)))
    else $error("emitted value is even or below two");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("output word overwritten");

endmodule

`default_nettype wire

// ===== bench/trial_division_prime_filter_test.sv =====
// Self-checking testbench for trial_division_prime_filter: candidate words in, primes out.
// A scoreboard class predicts which candidates come back; depends on the RTL top level only.
`timescale 1ns / 1ps

class prime_scoreboard;
  logic [31:0] bound;
  logic [31:0] expected_primes[$];
  int          errors;
  int          mismatches;
  int          tested;
  int          primes_seen;

  function new();
    bound = 32'hFFFF_FFFF;
  endfunction

  function void set_bound(logic [31:0] value);
    bound = value;
  endfunction

  function int pending();
    return expected_primes.size();
  endfunction

  // trial division by 2, then by odd divisors up to the square root
  function bit is_prime(logic [31:0] n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_candidate(logic [31:0] candidate);
    tested++;
    if (candidate < bound && is_prime(candidate)) expected_primes.push_back(candidate);
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  function void check_prime(logic [31:0] value);
    logic [31:0] want;
    primes_seen++;
    if (expected_primes.size() == 0) begin
      report("unexpected prime_value", 32'd0, value);
      return;
    end
    want = expected_primes.pop_front();
    if (value !== want) report("prime_value", want, value);
  endfunction

  function void check_drained();
    while (expected_primes.size() != 0) begin
      report("missing prime_value", expected_primes.pop_front(), 32'd0);
    end
  endfunction
endclass

module trial_division_prime_filter_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;      // [31:0] candidate
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;             // [31:0] prime_value
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;   // [31:0] upper_bound

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int              bound_writes = 0;
  prime_scoreboard sb = new();

  trial_division_prime_filter #(.VALUE_WIDTH(32)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_candidate(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_prime(out_tdata);
  end

  task automatic send_word(logic [31:0] candidate);
    in_tvalid <= 1'b1;
    in_tdata  <= candidate;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // hold input until all primes are back and the sequencer is idle again
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    do @(posedge clk); while (!in_tready || out_tvalid);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bound(logic [31:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_bound(value);
    bound_writes++;
  endtask

  function automatic logic [31:0] pick_candidate();
    int unsigned factors[6] = '{2, 3, 5, 7, 11, 13};
    int unsigned kind;
    int unsigned p;
    kind = $urandom_range(99);
    if (kind < 40) return $urandom_range(4095);
    if (kind < 55) return $urandom_range(65535);
    if (kind < 75) begin
      p = factors[$urandom_range(5)];
      return p * $urandom_range(32'hFFFF_FFFF / p);
    end
    if (kind < 88) begin
      if (sb.bound > 0 && sb.bound <= 70000) return sb.bound - 1 + $urandom_range(2);
      return $urandom_range(4095);
    end
    if (sb.bound <= 32'h8000_0000) return $urandom | 32'h8000_0000;
    return $urandom_range(255);
  endfunction

  task automatic run_phase(logic [31:0] bound, int items, int unsigned idle_pct,
                           int unsigned stall_pct);
    write_bound(bound);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      send_word(pick_candidate());
      if (i == items / 2 && idle_pct != 0) drain();
    end
  endtask

  initial begin
    logic [31:0] directed[15] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
                                  32'd121, 32'd7919, 32'd65521, 32'd16777213,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0001};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i]);
    write_bound(32'd100);
    send_word(32'd97);
    send_word(32'd99);
    send_word(32'd100);
    send_word(32'd101);
    write_bound(32'd3);
    send_word(32'd2);
    send_word(32'd3);
    write_bound(32'd0);
    send_word(32'd0);
    send_word(32'd2);
    send_word(32'hFFFF_FFFF);

    run_phase(32'hFFFF_FFFF, 112, 0, 0);
    run_phase(32'd5000, 112, 76, 0);
    run_phase(32'd65536, 112, 0, 76);
    run_phase(32'h8000_0000, 112, 6, 6);
    run_phase($urandom_range(2, 70000), 112, 76, 76);

    drain();
    repeat (50) @(posedge clk);
    sb.check_drained();
    $display("Tested %0d candidates over %0d bound settings with varied idle and stall;",
             sb.tested, bound_writes);
    $display("%0d primes returned, %0d mismatches.", sb.primes_seen, sb.mismatches);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d primes still awaited", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
